>>> hdl/grid_trilinear_interpolator_unit_assert.svh
// Assertion macros used by the interpolator RTL.
`ifndef GRID_TRILINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define GRID_TRILINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/gti_pkg.sv
package gti_pkg;

	typedef logic [1:0]         status_t;
	typedef logic [4:0]         count_t;
	typedef logic [3:0]         index_t;
	typedef logic signed [31:0] sample_t;

	localparam logic [2:0] REG_GRID_SHAPE = 3'd0;
	localparam logic [2:0] REG_X_ORIGIN   = 3'd1;
	localparam logic [2:0] REG_Y_ORIGIN   = 3'd2;
	localparam logic [2:0] REG_Z_ORIGIN   = 3'd3;
	localparam logic [2:0] REG_X_SCALE    = 3'd4;
	localparam logic [2:0] REG_Y_SCALE    = 3'd5;
	localparam logic [2:0] REG_Z_SCALE    = 3'd6;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_BAD_INDEX = 2'd1;
	localparam status_t STATUS_CLAMPED   = 2'd2;

	localparam int SCALED_BITS = 40;
	localparam int AXES        = 3;
	localparam int BANKS       = 8;
	localparam int BANK_DEPTH  = 512;

	localparam logic [14:0] SHAPE_RESET = 15'd1057;
	localparam logic [31:0] SCALE_RESET = 32'h0100_0000;

	function automatic count_t count_of(input logic [4:0] field, input count_t max_points);
		count_t n;
		if (field == 5'd0) begin
			n = 5'd1;
		end else if (field > max_points) begin
			n = max_points;
		end else begin
			n = field;
		end
		return n;
	endfunction

endpackage

>>> hdl/gti_if.sv
interface gti_query_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [3:0]         entry_x;
	logic [3:0]         entry_y;
	logic [3:0]         entry_z;
	logic signed [31:0] entry_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source (output valid, kind, entry_x, entry_y, entry_z, entry_value,
		pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, kind, entry_x, entry_y, entry_z, entry_value,
		pos_x, pos_y, pos_z, output ready);
endinterface

interface gti_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] interp_value;
	logic [1:0]         status;

	modport source (output valid, interp_value, status, input ready);
	modport sink (input valid, interp_value, status, output ready);
endinterface

>>> hdl/grid_trilinear_interpolator_unit.sv
// Channel   Direction  Contents
// query     in         kind, entry_x/y/z, entry_value, pos_x/y/z
// result    out        interp_value, status
// cfg_*     in         write enable, register index, data
//
// One word enters per cycle unless a stalled result holds the pipe; a word leaves from the stage 9 register.
// Writes reach the eight parity banks as the word leaves stage 1, ahead of any later query read.
// Reset clears the valid bits and loads the register defaults; the grid holds no reset value.
// A stalled result freezes every stage, and query.ready falls in the same cycle.
module grid_trilinear_interpolator_unit
	import gti_pkg::*;
#(
	parameter int MAX_X_POINTS  = 16,
	parameter int MAX_Y_POINTS  = 16,
	parameter int MAX_Z_POINTS  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	gti_query_if.sink           query,
	gti_result_if.source        result
);

	`include "grid_trilinear_interpolator_unit_assert.svh"

	localparam int FB = FRACTION_BITS;
	localparam int PW = FB + 34;
	localparam logic [FB:0] FRAC_ONE = (FB + 1)'(1) << FB;
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (FB - 1);

	function automatic logic signed [32:0] lerp_sum(input logic signed [PW-1:0] p,
		input logic signed [PW-1:0] q);
		logic signed [PW:0] s;
		logic signed [PW:0] t;
		s = $signed({p[PW-1], p}) + $signed({q[PW-1], q}) + $signed(HALF);
		t = s >>> FB;
		return t[32:0];
	endfunction

	logic [14:0] grid_shape_q;
	logic signed [31:0] origin_q [AXES];
	logic [31:0] scale_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_shape_q <= SHAPE_RESET;
			for (int a = 0; a < AXES; a++) begin
				origin_q[a] <= '0;
				scale_q[a] <= SCALE_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_SHAPE: grid_shape_q <= cfg_data[14:0];
				REG_X_ORIGIN:   origin_q[0] <= cfg_data;
				REG_Y_ORIGIN:   origin_q[1] <= cfg_data;
				REG_Z_ORIGIN:   origin_q[2] <= cfg_data;
				REG_X_SCALE:    scale_q[0] <= cfg_data;
				REG_Y_SCALE:    scale_q[1] <= cfg_data;
				REG_Z_SCALE:    scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	count_t n [AXES];
	assign n[0] = count_of(grid_shape_q[4:0], 5'(MAX_X_POINTS));
	assign n[1] = count_of(grid_shape_q[9:5], 5'(MAX_Y_POINTS));
	assign n[2] = count_of(grid_shape_q[14:10], 5'(MAX_Z_POINTS));

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	assign adv = !v_s9 || result.ready;
	assign query.ready = adv;

	// Stage 1: distance from the origin; writes reach the banks as they leave this stage.
	logic in_range;
	logic [2:0] wbank;
	logic [8:0] waddr;
	logic signed [31:0] pos [AXES];
	logic kind_s1;
	status_t status_s1;
	logic signed [32:0] diff_s1 [AXES];
	logic wen_s1;
	logic [2:0] wbank_s1;
	logic [8:0] waddr_s1;
	sample_t wdata_s1;

	assign pos[0] = query.pos_x;
	assign pos[1] = query.pos_y;
	assign pos[2] = query.pos_z;
	assign in_range = ({1'b0, query.entry_x} < n[0]) && ({1'b0, query.entry_y} < n[1])
		&& ({1'b0, query.entry_z} < n[2]);
	assign wbank = {query.entry_x[0], query.entry_y[0], query.entry_z[0]};
	assign waddr = {query.entry_x[3:1], query.entry_y[3:1], query.entry_z[3:1]};

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= query.kind;
			status_s1 <= (query.kind == KIND_WRITE && !in_range) ? STATUS_BAD_INDEX : STATUS_OK;
			wen_s1 <= query.kind == KIND_WRITE && in_range;
			wbank_s1 <= wbank;
			waddr_s1 <= waddr;
			wdata_s1 <= query.entry_value;
			for (int a = 0; a < AXES; a++) begin
				diff_s1[a] <= 33'(pos[a]) - 33'(origin_q[a]);
			end
		end
	end

	// Stage 2: scale into grid units, Q24.40.
	logic kind_s2;
	status_t status_s2;
	logic neg_s2 [AXES];
	logic [63:0] prod_s2 [AXES];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			status_s2 <= status_s1;
			for (int a = 0; a < AXES; a++) begin
				neg_s2[a] <= diff_s1[a][32];
				prod_s2[a] <= 64'(diff_s1[a][31:0]) * 64'(scale_q[a]);
			end
		end
	end

	// Stage 3: cell index and fraction per axis, bank read of all eight corners.
	index_t idx [AXES];
	logic [FB:0] frac [AXES];
	logic clp [AXES];
	logic [23:0] whole [AXES];
	logic [23:0] lim [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			idx[a] = '0;
			frac[a] = '0;
			clp[a] = 1'b0;
			whole[a] = prod_s2[a][63:SCALED_BITS];
			lim[a] = 24'(n[a] - 5'd1);
			if (n[a] > 5'd1) begin
				if (neg_s2[a]) begin
					clp[a] = scale_q[a] != '0;
				end else if (whole[a] > lim[a] || (whole[a] == lim[a]
					&& prod_s2[a][SCALED_BITS-1:0] != '0)) begin
					clp[a] = 1'b1;
					idx[a] = 4'(n[a] - 5'd2);
					frac[a] = FRAC_ONE;
				end else if (whole[a] == lim[a]) begin
					idx[a] = 4'(n[a] - 5'd2);
					frac[a] = FRAC_ONE;
				end else begin
					idx[a] = whole[a][3:0];
					frac[a] = {1'b0, prod_s2[a][SCALED_BITS-1 -: FB]};
				end
			end
		end
	end

	logic [31:0] rdata [BANKS];

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		localparam logic [2:0] BSEL = 3'(b);
		index_t xs, ys, zs;
		assign xs = (idx[0][0] == BSEL[2]) ? idx[0] : idx[0] + 4'd1;
		assign ys = (idx[1][0] == BSEL[1]) ? idx[1] : idx[1] + 4'd1;
		assign zs = (idx[2][0] == BSEL[0]) ? idx[2] : idx[2] + 4'd1;
		gti_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_bank (
			.clk   (clk),
			.we    (v_s1 && adv && wen_s1 && wbank_s1 == BSEL),
			.waddr (waddr_s1),
			.wdata (wdata_s1),
			.re    (adv),
			.raddr ({xs[3:1], ys[3:1], zs[3:1]}),
			.rdata (rdata[b])
		);
	end

	logic kind_s3;
	status_t status_s3;
	logic [2:0] par_s3;
	logic [2:0] st_s3;
	logic [FB:0] fx_s3, fy_s3, fz_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3 <= kind_s2;
			status_s3 <= (kind_s2 == KIND_QUERY) ? ((clp[0] || clp[1] || clp[2]) ?
				STATUS_CLAMPED : STATUS_OK) : status_s2;
			par_s3 <= {idx[0][0], idx[1][0], idx[2][0]};
			st_s3 <= {n[0] > 5'd1, n[1] > 5'd1, n[2] > 5'd1};
			fx_s3 <= frac[0];
			fy_s3 <= frac[1];
			fz_s3 <= frac[2];
		end
	end

	// Stage 4: corner products along x.
	// On an axis with a single point, the far corner is the near corner.
	logic kind_s4;
	status_t status_s4;
	logic [FB:0] fy_s4, fz_s4;
	logic signed [PW-1:0] pa_s4 [4];
	logic signed [PW-1:0] pb_s4 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s4 <= kind_s3;
			status_s4 <= status_s3;
			fy_s4 <= fy_s3;
			fz_s4 <= fz_s3;
			for (int m = 0; m < 4; m++) begin
				pa_s4[m] <= $signed(rdata[(3'(m) & st_s3) ^ par_s3])
					* $signed({1'b0, FRAC_ONE - fx_s3});
				pb_s4[m] <= $signed(rdata[((3'd4 | 3'(m)) & st_s3) ^ par_s3])
					* $signed({1'b0, fx_s3});
			end
		end
	end

	// Stage 5: x results.
	logic kind_s5;
	status_t status_s5;
	logic [FB:0] fy_s5, fz_s5;
	sample_t cx_s5 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s5 <= kind_s4;
			status_s5 <= status_s4;
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;
			for (int m = 0; m < 4; m++) begin
				cx_s5[m] <= 32'(lerp_sum(pa_s4[m], pb_s4[m]));
			end
		end
	end

	// Stage 6: products along y.
	logic kind_s6;
	status_t status_s6;
	logic [FB:0] fz_s6;
	logic signed [PW-1:0] pa_s6 [2];
	logic signed [PW-1:0] pb_s6 [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s6 <= kind_s5;
			status_s6 <= status_s5;
			fz_s6 <= fz_s5;
			for (int m = 0; m < 2; m++) begin
				pa_s6[m] <= $signed(cx_s5[m]) * $signed({1'b0, FRAC_ONE - fy_s5});
				pb_s6[m] <= $signed(cx_s5[m + 2]) * $signed({1'b0, fy_s5});
			end
		end
	end

	// Stage 7: y results.
	logic kind_s7;
	status_t status_s7;
	logic [FB:0] fz_s7;
	sample_t cy_s7 [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s7 <= kind_s6;
			status_s7 <= status_s6;
			fz_s7 <= fz_s6;
			for (int m = 0; m < 2; m++) begin
				cy_s7[m] <= 32'(lerp_sum(pa_s6[m], pb_s6[m]));
			end
		end
	end

	// Stage 8: products along z.
	logic kind_s8;
	status_t status_s8;
	logic signed [PW-1:0] pa_s8, pb_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s8 <= kind_s7;
			status_s8 <= status_s7;
			pa_s8 <= $signed(cy_s7[0]) * $signed({1'b0, FRAC_ONE - fz_s7});
			pb_s8 <= $signed(cy_s7[1]) * $signed({1'b0, fz_s7});
		end
	end

	// Stage 9: final sum, saturation and output register.
	logic signed [32:0] r;
	sample_t r_sat;
	logic kind_s9;
	sample_t value_s9;
	status_t status_s9;

	assign r = lerp_sum(pa_s8, pb_s8);
	assign r_sat = (r > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(r < -33'sh0_8000_0000) ? 32'sh8000_0000 : r[31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s9 <= kind_s8;
			status_s9 <= status_s8;
			value_s9 <= (kind_s8 == KIND_QUERY) ? r_sat : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign result.valid = v_s9;
	assign result.interp_value = value_s9;
	assign result.status = status_s9;

	`GTI_ASSERT_NOW(a_write_zero, v_s9 && kind_s9 == KIND_WRITE, value_s9 == '0,
		"write word produced a nonzero value")
	`GTI_ASSERT_NOW(a_clamp_query, v_s9 && status_s9 == STATUS_CLAMPED, kind_s9 == KIND_QUERY,
		"clamp status on a write word")
	`GTI_ASSERT_NOW(a_frac_range, v_s3, fx_s3 <= FRAC_ONE && fy_s3 <= FRAC_ONE
		&& fz_s3 <= FRAC_ONE, "fraction above one")
	`GTI_ASSERT_NEXT(a_stall_hold, !adv, $stable(v_s1) && $stable(v_s5) && $stable(value_s9),
		"pipeline moved during a stall")

endmodule

>>> hdl/gti_ram.sv
module gti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> tb/sv/tb.sv
module tb
	import gti_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic        kind;
		index_t      ex, ey, ez;
		sample_t     value;
		sample_t     px, py, pz;
	} word_t;

	typedef struct {
		sample_t value;
		status_t status;
	} outcome_t;

	typedef struct {
		int     i, i1, j, j1, k, k1;
		longint fx, fy, fz;
		bit     clamped;
	} spot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	gti_query_if query ();
	gti_result_if result ();

	grid_trilinear_interpolator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .query(query), .result(result)
	);

	always #5 clk = ~clk;

	logic [14:0] shape_reg;
	longint      org_x, org_y, org_z;
	logic [31:0] scl_x, scl_y, scl_z;
	logic [31:0] grid_mem [4096];
	bit          filled [4096];

	word_t    pending [$];
	outcome_t expected [$];
	word_t    cur;
	int queued, accepted, received, errors, cycles;
	int n_writes, n_queries, n_clamped, n_bad, n_phases;
	int send_gap, recv_gap;
	bit quiet;

	function automatic int cnt(input logic [4:0] f);
		if (f == 0) return 1;
		if (f > 16) return 16;
		return f;
	endfunction

	function automatic void locate(input sample_t pos, input longint org, input logic [31:0] s,
		input int n, input bit active, output int idx, output longint f, inout bit clamped);
		longint diff;
		longint unsigned prod, lim, ip;
		idx = 0;
		f = 0;
		if (!active || n < 2) return;
		diff = longint'(pos) - org;
		if (diff < 0) begin
			if (s != 0) clamped = 1'b1;
			return;
		end
		prod = longint'(unsigned'(diff)) * longint'({32'd0, s});
		lim = longint'(n - 1) << SCALED_BITS;
		ip = prod >> SCALED_BITS;
		if (prod > lim) begin
			clamped = 1'b1;
			idx = n - 2;
			f = ONE;
		end else if (ip >= n - 1) begin
			idx = n - 2;
			f = ONE;
		end else begin
			idx = int'(ip);
			f = longint'((prod >> (SCALED_BITS - FB)) & (ONE - 1));
		end
	endfunction

	function automatic spot_t find_cell(input word_t w);
		spot_t sp;
		int nx, ny, nz;
		bit uz, uy, ux;
		nx = cnt(shape_reg[4:0]);
		ny = cnt(shape_reg[9:5]);
		nz = cnt(shape_reg[14:10]);
		uz = nz > 1;
		uy = uz || ny > 1;
		ux = uy || nx > 1;
		sp.clamped = 1'b0;
		locate(w.px, org_x, scl_x, nx, ux, sp.i, sp.fx, sp.clamped);
		locate(w.py, org_y, scl_y, ny, uy, sp.j, sp.fy, sp.clamped);
		locate(w.pz, org_z, scl_z, nz, uz, sp.k, sp.fz, sp.clamped);
		sp.i1 = (nx > 1 && ux) ? sp.i + 1 : sp.i;
		sp.j1 = (ny > 1 && uy) ? sp.j + 1 : sp.j;
		sp.k1 = (nz > 1 && uz) ? sp.k + 1 : sp.k;
		return sp;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint f);
		return (a * (ONE - f) + b * f + (ONE >>> 1)) >>> FB;
	endfunction

	function automatic longint sample_at(input int x, input int y, input int z);
		return longint'(signed'(grid_mem[x * 256 + y * 16 + z]));
	endfunction

	function automatic outcome_t interpolate(input word_t w);
		outcome_t o;
		spot_t sp;
		longint c00, c10, c01, c11, c0, c1, r;
		o.value = 0;
		if (w.kind == KIND_WRITE) begin
			if (w.ex >= cnt(shape_reg[4:0]) || w.ey >= cnt(shape_reg[9:5]) ||
					w.ez >= cnt(shape_reg[14:10])) begin
				o.status = STATUS_BAD_INDEX;
			end else begin
				grid_mem[w.ex * 256 + w.ey * 16 + w.ez] = w.value;
				o.status = STATUS_OK;
			end
			return o;
		end
		sp = find_cell(w);
		c00 = blend(sample_at(sp.i, sp.j, sp.k), sample_at(sp.i1, sp.j, sp.k), sp.fx);
		c10 = blend(sample_at(sp.i, sp.j1, sp.k), sample_at(sp.i1, sp.j1, sp.k), sp.fx);
		c01 = blend(sample_at(sp.i, sp.j, sp.k1), sample_at(sp.i1, sp.j, sp.k1), sp.fx);
		c11 = blend(sample_at(sp.i, sp.j1, sp.k1), sample_at(sp.i1, sp.j1, sp.k1), sp.fx);
		c0 = blend(c00, c10, sp.fy);
		c1 = blend(c01, c11, sp.fy);
		r = blend(c0, c1, sp.fz);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		o.value = sample_t'(r);
		o.status = sp.clamped ? STATUS_CLAMPED : STATUS_OK;
		return o;
	endfunction

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void push_write(input int x, input int y, input int z, input sample_t v);
		word_t w;
		w = '{KIND_WRITE, index_t'(x), index_t'(y), index_t'(z), v,
			sample_t'($urandom), sample_t'($urandom), sample_t'($urandom)};
		if (x < cnt(shape_reg[4:0]) && y < cnt(shape_reg[9:5]) && z < cnt(shape_reg[14:10]))
			filled[x * 256 + y * 16 + z] = 1'b1;
		pending.push_back(w);
		queued++;
	endfunction

	// Any corner a query would read is written first, so no unwritten entry is ever read.
	function automatic void push_query(input sample_t x, input sample_t y, input sample_t z);
		word_t w;
		spot_t sp;
		int xs[2], ys[2], zs[2];
		w = '{KIND_QUERY, index_t'($urandom), index_t'($urandom), index_t'($urandom),
			sample_t'($urandom), x, y, z};
		sp = find_cell(w);
		xs = '{sp.i, sp.i1};
		ys = '{sp.j, sp.j1};
		zs = '{sp.k, sp.k1};
		foreach (xs[a]) foreach (ys[b]) foreach (zs[c])
			if (!filled[xs[a] * 256 + ys[b] * 16 + zs[c]])
				push_write(xs[a], ys[b], zs[c], sample_t'($urandom));
		pending.push_back(w);
		queued++;
	endfunction

	function automatic sample_t pos_in(input int n, input longint org, input logic [31:0] s);
		longint span, off, p;
		if (n < 2 || $urandom_range(0, 9) == 0) return sample_t'($urandom);
		span = (s == 0) ? (64'sd1 << 20) : ((longint'(n - 1) << SCALED_BITS) / s);
		if (span > (64'sd1 << 33)) span = 64'sd1 << 33;
		case ($urandom_range(0, 7))
			0: off = span;
			1: off = 0;
			default: off = longint'({$urandom, $urandom} % (span * 9 / 8 + 1)) - span / 16;
		endcase
		p = org + off;
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return sample_t'(p);
	endfunction

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_GRID_SHAPE: shape_reg = v[14:0];
			REG_X_ORIGIN: org_x = longint'(signed'(v));
			REG_Y_ORIGIN: org_y = longint'(signed'(v));
			REG_Z_ORIGIN: org_z = longint'(signed'(v));
			REG_X_SCALE: scl_x = v;
			REG_Y_SCALE: scl_y = v;
			default: scl_z = v;
		endcase
	endtask

	task automatic drain();
		wait (pending.size() == 0 && accepted == queued && received == queued);
		repeat (12) @(posedge clk);
	endtask

	task automatic run_phase(input logic [14:0] sh, input logic [31:0] ox, oy, oz,
		input logic [31:0] sx, sy, sz, input int items);
		int base;
		drain();
		set_reg(REG_GRID_SHAPE, {17'd0, sh});
		set_reg(REG_X_ORIGIN, ox);
		set_reg(REG_Y_ORIGIN, oy);
		set_reg(REG_Z_ORIGIN, oz);
		set_reg(REG_X_SCALE, sx);
		set_reg(REG_Y_SCALE, sy);
		set_reg(REG_Z_SCALE, sz);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_phases++;
		base = queued;
		while (queued - base < items) begin
			case ($urandom_range(0, 9))
				0, 1, 2: push_write($urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 15), sample_t'($urandom));
				3: push_query(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
				default: push_query(pos_in(cnt(sh[4:0]), org_x, scl_x),
					pos_in(cnt(sh[9:5]), org_y, scl_y), pos_in(cnt(sh[14:10]), org_z, scl_z));
			endcase
		end
	endtask

	function automatic logic [14:0] rand_shape();
		logic [4:0] f[3];
		foreach (f[a]) f[a] = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
			: 5'($urandom_range(0, 5));
		return {f[2], f[1], f[0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query.valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (query.valid && query.ready) begin
				expected.push_back(interpolate(cur));
				accepted++;
				if (cur.kind == KIND_WRITE) n_writes++;
				else n_queries++;
			end
			if (!query.valid || query.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					query.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					query.valid <= 1'b1;
					query.kind <= cur.kind;
					query.entry_x <= cur.ex;
					query.entry_y <= cur.ey;
					query.entry_z <= cur.ez;
					query.entry_value <= cur.value;
					query.pos_x <= cur.px;
					query.pos_y <= cur.py;
					query.pos_z <= cur.pz;
					if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
				end else begin
					query.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (result.valid && result.ready) begin
				received++;
				if (expected.size() == 0) begin
					report("result word with nothing expected");
				end else begin
					want = expected.pop_front();
					if (result.interp_value !== want.value)
						report($sformatf("interp_value %0d, expected %0d",
							result.interp_value, want.value));
					if (result.status !== want.status)
						report($sformatf("status %0d, expected %0d", result.status, want.status));
					if (want.status == STATUS_CLAMPED) n_clamped++;
					if (want.status == STATUS_BAD_INDEX) n_bad++;
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 5);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		cfg_we = 1'b0;
		cfg_index = REG_GRID_SHAPE;
		cfg_data = '0;
		query.valid = 1'b0;
		query.kind = KIND_WRITE;
		query.entry_x = '0;
		query.entry_y = '0;
		query.entry_z = '0;
		query.entry_value = '0;
		query.pos_x = '0;
		query.pos_y = '0;
		query.pos_z = '0;
		result.ready = 1'b0;
		shape_reg = SHAPE_RESET;
		org_x = 0;
		org_y = 0;
		org_z = 0;
		scl_x = SCALE_RESET;
		scl_y = SCALE_RESET;
		scl_z = SCALE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset shape is a single point, so a query returns entry zero.
		push_write(0, 0, 0, 32'sh7FFF_FFFF);
		push_write(1, 0, 0, 32'sh1234);
		push_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000);

		drain();
		set_reg(REG_GRID_SHAPE, {17'd0, 5'd2, 5'd2, 5'd2});
		@(posedge clk);
		cfg_we <= 1'b0;
		push_write(0, 0, 0, 32'sh7FFF_FFFF);
		push_write(1, 0, 0, 32'sh8000_0000);
		push_write(0, 1, 0, 32'sh0000_0000);
		push_write(1, 1, 0, -32'sd1);
		push_write(0, 0, 1, 32'sh0001_8000);
		push_write(1, 0, 1, -32'sh0003_0000);
		push_write(0, 1, 1, 32'sh7FFF_0000);
		push_write(1, 1, 1, 32'sh8001_0000);
		push_write(15, 0, 0, 32'sh1);
		push_write(0, 2, 0, 32'sh1);
		push_write(0, 0, 15, 32'sh1);
		push_query(0, 0, 0);
		push_query(32'sh8000, 32'sh8000, 32'sh8000);
		push_query(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
		push_query(32'sh3_0000, 32'sh4000, 32'sh0);
		push_query(-32'sd1, 32'sh8000, 32'sh1_0000);
		push_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_FFFF);
		push_query(32'sh0000_0001, 32'sh0000_7FFF, 32'sh0000_8001);

		run_phase(15'd0, 32'h0, 32'h0, 32'h0, SCALE_RESET, SCALE_RESET, SCALE_RESET, 120);
		run_phase({5'd1, 5'd1, 5'd16}, $urandom, $urandom, $urandom,
			$urandom_range(1 << 20, 1 << 28), $urandom, $urandom, 160);
		run_phase({5'd1, 5'd7, 5'd5}, 32'hFFFF_0000, 32'h0002_0000, 32'h0,
			32'h0080_0000, 32'h0200_0000, SCALE_RESET, 160);
		run_phase({5'd3, 5'd3, 5'd3}, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 150);
		run_phase({5'd2, 5'd4, 5'd2}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0, 32'h0, 32'h0, 120);
		run_phase(15'h7FFF, $urandom_range(0, 1 << 20), 32'h0, 32'hFFF0_0000,
			32'h0010_0000, 32'h0010_0000, 32'h0020_0000, 160);
		repeat (4)
			run_phase(rand_shape(), $urandom, $urandom, $urandom,
				$urandom_range(1 << 20, 1 << 28), $urandom_range(1 << 20, 1 << 28),
				$urandom_range(1 << 20, 1 << 28), 160);
		drain();
		quiet = 1'b1;
		run_phase(rand_shape(), $urandom, $urandom, $urandom,
			$urandom_range(1 << 22, 1 << 26), $urandom_range(1 << 22, 1 << 26),
			$urandom_range(1 << 22, 1 << 26), 150);
		drain();
		if (expected.size() != 0) report($sformatf("%0d results never arrived", expected.size()));

		$display("Ran %0d writes and %0d queries over %0d register settings.",
			n_writes, n_queries, n_phases);
		$display("Saw %0d clamped queries and %0d out-of-range writes.", n_clamped, n_bad);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/gti_pkg.sv
hdl/gti_if.sv
hdl/gti_ram.sv
hdl/grid_trilinear_interpolator_unit.sv
tb/sv/tb.sv
